// ===== hdl/rtu_serial_link_framer_assert.svh =====
// assertion macros used by the serial link framer rtl
`ifndef RTU_SERIAL_LINK_FRAMER_ASSERT_SVH
`define RTU_SERIAL_LINK_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, quiet while reset is low
`define RTU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds through reset
`define RTU_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define RTU_ASSERT(name, prop, msg)
`define RTU_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// ===== hdl/rtu_slf_pkg.sv =====
// types and constants of the serial link framer
`timescale 1ns / 1ps
`default_nettype none

package rtu_slf_pkg;

  // input word operation
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_RX_BYTE = 2'd1,
    OP_QUEUE   = 2'd2,
    OP_TX_DONE = 2'd3
  } opcode_e;

  // result word event
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_STORE = 2'd1,
    EV_FRAME = 2'd2,
    EV_SEND  = 2'd3
  } event_e;

  // receive phase
  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_IDLE = 2'd1,
    PH_RECV = 2'd2
  } rx_phase_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_GAP  = 2'd1;

  localparam logic [3:0] FRAME_GAP_RESET = 4'd7;
  localparam logic [3:0] CHAR_GAP_RESET  = 4'd3;
  localparam logic [7:0] GAP_MAX         = 8'hFF;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] data_byte;
    logic       line_error;
  } item_t;

  typedef struct packed {
    event_e     event_kind;
    logic [7:0] rx_index;
    logic [7:0] rx_byte;
    logic [8:0] frame_length;
    logic [7:0] gap_count;
    logic [7:0] tx_byte;
    logic       drive_enable;
    rx_phase_e  rx_phase;
    logic       tx_busy;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [3:0]           value;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/rtu_slf_stream_if.sv =====
// valid/ready channel carrying one word of a given type
`timescale 1ns / 1ps
`default_nettype none

interface rtu_slf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rtu_serial_link_framer.sv =====
// half-duplex serial link framer with silence based frame timing
//
// The block takes one input word per clock: a half-character tick, a received
// byte, a byte queued for sending or a transmit-complete event. Every accepted
// word gives exactly one result word, registered through an output
// register backed by a one-word skid stage, so words may be offered in every
// cycle and the input stalls only while both output stages are full. All
// state moves in a single registered update per word. Queued transmit bytes
// wait in a BUF_DEPTH-entry ram; the byte at the read position is fetched
// ahead (with a bypass for a byte written in the same cycle), so a
// transmit-complete word finds the next byte ready. The ram needs no clearing
// after reset. Configuration writes (frame gap, char gap) are always taken and
// must only be made while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "rtu_serial_link_framer_assert.svh"

module rtu_serial_link_framer #(
  parameter int unsigned BUF_DEPTH = 256
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  rtu_slf_stream_if.sink   cfg_i,
  rtu_slf_stream_if.sink   item_i,
  rtu_slf_stream_if.source result_o
);

  import rtu_slf_pkg::*;

  localparam int unsigned PW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);
  localparam int unsigned QW = $clog2(BUF_DEPTH + 2);
  localparam logic [PW-1:0] LAST_POS = PW'(BUF_DEPTH - 1);
  localparam logic [CW-1:0] RX_LIMIT = CW'(BUF_DEPTH);
  localparam logic [QW-1:0] TX_LIMIT = QW'(BUF_DEPTH);

  // configuration registers
  logic [3:0] frame_gap_q, char_gap_q;
  item_t      item;
  cfg_t       cfg;

  assign cfg         = cfg_i.data;
  assign item        = item_i.data;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_gap_q <= FRAME_GAP_RESET;
      char_gap_q  <= CHAR_GAP_RESET;
    end else if (cfg_i.valid) begin
      if (cfg.index == CFG_FRAME_GAP) begin
        frame_gap_q <= cfg.value;
      end
      if (cfg.index == CFG_CHAR_GAP) begin
        char_gap_q <= cfg.value;
      end
    end
  end

  // framer state
  rx_phase_e   phase_q, phase_d;
  logic        tx_q, tx_d;
  logic        tmr_q, tmr_d;
  logic [3:0]  half_q, half_d;
  logic [7:0]  gap_q, gap_d;
  logic [CW-1:0] rcnt_q, rcnt_d;
  logic [QW-1:0] pend_q, pend_d;
  logic [PW-1:0] rd_pos_q, rd_pos_d;
  logic [PW-1:0] wr_pos_q, wr_pos_d;
  logic [QW-1:0] pend_dec;

  // output register and skid stage
  logic    ov_q, sv_q;
  result_t od_q, sd_q;
  result_t res;
  logic    in_acc;

  assign item_i.ready = !sv_q;
  assign in_acc       = item_i.valid && !sv_q;

  // send store with one-ahead fetch of the read position
  logic       ram_we;
  logic [7:0] ram_rdata;
  logic       byp_q;
  logic [7:0] byp_data_q;
  logic [7:0] head;

  rtu_slf_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_send_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_pos_q),
    .wdata_i(item.data_byte),
    .raddr_i(rd_pos_d),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    byp_q      <= ram_we && (wr_pos_q == rd_pos_d);
    byp_data_q <= item.data_byte;
  end

  assign head     = byp_q ? byp_data_q : ram_rdata;
  assign pend_dec = (pend_q != '0) ? pend_q - QW'(1) : pend_q;

  // one word of work
  always_comb begin
    phase_d  = phase_q;
    tx_d     = tx_q;
    tmr_d    = tmr_q;
    half_d   = half_q;
    gap_d    = gap_q;
    rcnt_d   = rcnt_q;
    pend_d   = pend_q;
    rd_pos_d = rd_pos_q;
    wr_pos_d = wr_pos_q;
    ram_we   = 1'b0;
    res      = '0;
    if (in_acc) begin
      unique case (item.opcode)
        OP_TICK: begin
          if (tmr_q) begin
            half_d = half_q + 4'd1;
            if (half_d >= frame_gap_q) begin
              half_d = '0;
              if (phase_q == PH_RECV) begin
                res.event_kind   = EV_FRAME;
                res.frame_length = 9'(rcnt_q);
                res.gap_count    = (gap_q == '0) ? '0 : gap_q - 8'd1;
              end
              phase_d = PH_IDLE;
              tmr_d   = 1'b0;
              gap_d   = '0;
            end
            if (half_d == char_gap_q && gap_d != GAP_MAX) begin
              gap_d = gap_d + 8'd1;
            end
          end
        end
        OP_RX_BYTE: begin
          // reception is enabled exactly while not transmitting
          if (!item.line_error && !tx_q) begin
            if (phase_q == PH_IDLE) begin
              phase_d        = PH_RECV;
              rcnt_d         = CW'(1);
              res.event_kind = EV_STORE;
              res.rx_byte    = item.data_byte;
            end else if (phase_q == PH_RECV && rcnt_q < RX_LIMIT) begin
              res.event_kind = EV_STORE;
              res.rx_index   = 8'(rcnt_q);
              res.rx_byte    = item.data_byte;
              rcnt_d         = rcnt_q + CW'(1);
            end
            tmr_d  = 1'b1;
            half_d = '0;
          end
        end
        OP_QUEUE: begin
          if (!tx_q) begin
            tx_d           = 1'b1;
            rd_pos_d       = '0;
            wr_pos_d       = '0;
            pend_d         = QW'(1);
            res.event_kind = EV_SEND;
            res.tx_byte    = item.data_byte;
          end else if (pend_q <= TX_LIMIT) begin
            ram_we   = 1'b1;
            wr_pos_d = (wr_pos_q == LAST_POS) ? '0 : wr_pos_q + PW'(1);
            pend_d   = pend_q + QW'(1);
          end
        end
        OP_TX_DONE: begin
          if (tx_q) begin
            pend_d = pend_dec;
            if (pend_dec != '0) begin
              res.event_kind = EV_SEND;
              res.tx_byte    = head;
              rd_pos_d       = (rd_pos_q == LAST_POS) ? '0 : rd_pos_q + PW'(1);
            end else begin
              tx_d   = 1'b0;
              tmr_d  = 1'b1;
              half_d = '0;
            end
          end else begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
    res.drive_enable = tx_d;
    res.tx_busy      = tx_d;
    res.rx_phase     = phase_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_INIT;
      tx_q     <= 1'b0;
      tmr_q    <= 1'b0;
      half_q   <= '0;
      gap_q    <= '0;
      rcnt_q   <= '0;
      pend_q   <= '0;
      rd_pos_q <= '0;
      wr_pos_q <= '0;
    end else begin
      phase_q  <= phase_d;
      tx_q     <= tx_d;
      tmr_q    <= tmr_d;
      half_q   <= half_d;
      gap_q    <= gap_d;
      rcnt_q   <= rcnt_d;
      pend_q   <= pend_d;
      rd_pos_q <= rd_pos_d;
      wr_pos_q <= wr_pos_d;
    end
  end

  // output and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (!ov_q || result_o.ready) begin
      if (sv_q) begin
        ov_q <= 1'b1;
        sv_q <= 1'b0;
      end else begin
        ov_q <= in_acc;
      end
    end else if (in_acc) begin
      sv_q <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (!ov_q || result_o.ready) begin
      od_q <= sv_q ? sd_q : res;
    end else if (in_acc) begin
      sd_q <= res;
    end
  end

  assign result_o.valid = ov_q;
  assign result_o.data  = od_q;

  // checks
  `RTU_ASSERT_ALWAYS(a_skid_behind_out, sv_q |-> ov_q, "skid word held without output word")
  `RTU_ASSERT(a_pending_tracks_tx, tx_q == (pend_q != '0), "send count out of step with tx state")
  `RTU_ASSERT(a_pending_bound, pend_q <= TX_LIMIT + QW'(1), "send count beyond queue depth")
  `RTU_ASSERT(a_recv_timed, phase_q == PH_RECV |-> tmr_q, "receiving with silence timer stopped")
  `RTU_ASSERT(a_rx_bound, rcnt_q <= RX_LIMIT, "received count beyond buffer depth")

endmodule

`default_nettype wire

// ===== hdl/rtu_slf_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module rtu_slf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for the serial link framer: scripted and random traffic against a predictor
`timescale 1ns / 1ps

module testbench;
  import rtu_slf_pkg::*;

  localparam int unsigned DEPTH        = 256;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_TICKS = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rtu_slf_stream_if #(.T(cfg_t))    cfg_if ();
  rtu_slf_stream_if #(.T(item_t))   item_if ();
  rtu_slf_stream_if #(.T(result_t)) result_if ();

  rtu_serial_link_framer #(
    .BUF_DEPTH(DEPTH)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_if),
    .item_i  (item_if),
    .result_o(result_if)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // link state as the block should hold it
  logic [3:0]  frame_gap_cfg;
  logic [3:0]  char_gap_cfg;
  rx_phase_e   lk_phase;
  logic        lk_tx_on;
  logic        lk_timer_on;
  logic [3:0]  lk_half;
  logic [7:0]  lk_gaps;
  logic [8:0]  lk_rx_count;
  logic        lk_rx_en;
  logic [7:0]  lk_tx_store [DEPTH];
  logic [8:0]  lk_tx_pending;
  logic [7:0]  lk_tx_rd;
  logic [7:0]  lk_tx_wr;

  result_t     pending_results [$];

  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  bit          hold_trigger = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned errors       = 0;
  int unsigned items_sent   = 0;
  int unsigned words_seen   = 0;
  int unsigned frames_ended = 0;
  int unsigned bytes_out    = 0;

  // next result word of the link for one input word, updating the link state
  function automatic result_t link_result(item_t it);
    result_t r;
    r = '0;
    case (it.opcode)
      OP_TICK: begin
        if (lk_timer_on) begin
          lk_half = lk_half + 4'd1;
          // silence long enough: close the frame
          if (lk_half >= frame_gap_cfg) begin
            lk_half = '0;
            if (lk_phase == PH_RECV) begin
              r.event_kind   = EV_FRAME;
              r.frame_length = lk_rx_count;
              r.gap_count    = (lk_gaps == 8'd0) ? 8'd0 : lk_gaps - 8'd1;
            end
            lk_phase    = PH_IDLE;
            lk_timer_on = 1'b0;
            lk_gaps     = '0;
          end
          if (lk_half == char_gap_cfg && lk_gaps != GAP_MAX) lk_gaps = lk_gaps + 8'd1;
        end
      end
      OP_RX_BYTE: begin
        if (!it.line_error && !lk_tx_on && lk_rx_en) begin
          if (lk_phase == PH_IDLE) begin
            lk_phase    = PH_RECV;
            lk_rx_count = 9'd1;
            r.event_kind = EV_STORE;
            r.rx_index   = 8'd0;
            r.rx_byte    = it.data_byte;
          end else if (lk_phase == PH_RECV && lk_rx_count < DEPTH) begin
            r.event_kind = EV_STORE;
            r.rx_index   = lk_rx_count[7:0];
            r.rx_byte    = it.data_byte;
            lk_rx_count  = lk_rx_count + 9'd1;
          end
          lk_timer_on = 1'b1;
          lk_half     = '0;
        end
      end
      OP_QUEUE: begin
        // first byte goes out at once, later ones wait in the store
        if (!lk_tx_on) begin
          lk_tx_on      = 1'b1;
          lk_rx_en      = 1'b0;
          lk_tx_rd      = '0;
          lk_tx_wr      = '0;
          lk_tx_pending = 9'd1;
          r.event_kind  = EV_SEND;
          r.tx_byte     = it.data_byte;
        end else if (lk_tx_pending <= DEPTH) begin
          lk_tx_store[lk_tx_wr] = it.data_byte;
          lk_tx_wr      = lk_tx_wr + 8'd1;
          lk_tx_pending = lk_tx_pending + 9'd1;
        end
      end
      default: begin
        if (lk_tx_on) begin
          if (lk_tx_pending > 0) lk_tx_pending = lk_tx_pending - 9'd1;
          if (lk_tx_pending > 0) begin
            r.event_kind = EV_SEND;
            r.tx_byte    = lk_tx_store[lk_tx_rd];
            lk_tx_rd     = lk_tx_rd + 8'd1;
          end else begin
            lk_tx_on    = 1'b0;
            lk_rx_en    = 1'b1;
            lk_timer_on = 1'b1;
            lk_half     = '0;
          end
        end else begin
          lk_phase = PH_IDLE;
        end
      end
    endcase
    r.drive_enable = lk_tx_on;
    r.rx_phase     = lk_phase;
    r.tx_busy      = lk_tx_on;
    return r;
  endfunction

  // offer one input word, with random idle cycles ahead of it
  task automatic send_item(input opcode_e op, input logic [7:0] data, input logic err);
    item_t       it;
    result_t     r;
    int unsigned gap;
    it.opcode     = op;
    it.data_byte  = data;
    it.line_error = err;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    do @(posedge clk_i); while (!item_if.ready);
    r = link_result(it);
    pending_results.push_back(r);
    items_sent++;
    if (r.event_kind == EV_FRAME) frames_ended++;
    if (r.event_kind == EV_SEND) bytes_out++;
  endtask

  // stop offering and wait for every outstanding result word
  task automatic drain_results();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] value);
    cfg_t c;
    c.index = idx;
    c.value = value;
    drain_results();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_FRAME_GAP: frame_gap_cfg = value;
      CFG_CHAR_GAP:  char_gap_cfg  = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_gaps(input logic [3:0] frame_gap, input logic [3:0] char_gap);
    write_reg(CFG_FRAME_GAP, frame_gap);
    write_reg(CFG_CHAR_GAP, char_gap);
  endtask

  // ignored words, first byte in init, a short frame and a short transmission
  task automatic test_directed();
    send_item(OP_TICK, 8'h00, 1'b0);
    send_item(OP_RX_BYTE, 8'hFF, 1'b1);
    send_item(OP_RX_BYTE, 8'h42, 1'b0);
    send_item(OP_TX_DONE, 8'h00, 1'b0);
    send_item(OP_RX_BYTE, 8'h00, 1'b0);
    repeat (3) send_item(OP_TICK, 8'h00, 1'b0);
    send_item(OP_RX_BYTE, 8'hFF, 1'b0);
    send_item(OP_RX_BYTE, 8'h81, 1'b1);
    repeat (7) send_item(OP_TICK, 8'hFF, 1'b1);
    send_item(OP_QUEUE, 8'hA5, 1'b0);
    send_item(OP_QUEUE, 8'h5A, 1'b1);
    send_item(OP_RX_BYTE, 8'h3C, 1'b0);
    send_item(OP_TX_DONE, 8'h00, 1'b0);
    send_item(OP_TX_DONE, 8'hFF, 1'b1);
    send_item(OP_TX_DONE, 8'h00, 1'b0);
  endtask

  // one frame past the buffer depth, a gap after every byte so the gap count saturates
  task automatic test_rx_overflow();
    set_gaps(4'd15, 4'd1);
    send_item(OP_TX_DONE, 8'($urandom), 1'($urandom));
    repeat (DEPTH + 2) begin
      send_item(OP_RX_BYTE, 8'($urandom), 1'b0);
      send_item(OP_TICK, 8'($urandom), 1'($urandom));
    end
    while (lk_timer_on) send_item(OP_TICK, 8'($urandom), 1'($urandom));
  endtask

  // queue past the store depth, then drain the transmit side
  task automatic test_tx_queue_full();
    repeat (DEPTH + 4) send_item(OP_QUEUE, 8'($urandom), 1'($urandom));
    while (lk_tx_on) send_item(OP_TX_DONE, 8'($urandom), 1'($urandom));
    while (lk_timer_on) send_item(OP_TICK, 8'($urandom), 1'($urandom));
  endtask

  // mostly well formed frames and transmissions, some loose words
  task automatic test_traffic(input int unsigned count);
    int unsigned first;
    int unsigned pick;
    first = items_sent;
    while (items_sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        while (lk_tx_on) send_item(OP_TX_DONE, 8'($urandom), 1'($urandom));
        if (lk_phase == PH_INIT) send_item(OP_TX_DONE, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(1, 10)) begin
          send_item(OP_RX_BYTE, 8'($urandom), $urandom_range(9) == 0);
          repeat ($urandom_range(0, frame_gap_cfg))
            send_item(OP_TICK, 8'($urandom), 1'($urandom));
        end
        while (lk_timer_on) send_item(OP_TICK, 8'($urandom), 1'($urandom));
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 8)) begin
          send_item(OP_QUEUE, 8'($urandom), 1'($urandom));
          if ($urandom_range(3) == 0) send_item(OP_RX_BYTE, 8'($urandom), 1'($urandom));
        end
        while (lk_tx_on) begin
          send_item(OP_TX_DONE, 8'($urandom), 1'($urandom));
          if ($urandom_range(4) == 0) send_item(OP_TICK, 8'($urandom), 1'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(opcode_e'($urandom_range(3)), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, then the sender waits it out
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    hold_trigger = 1'b1;
    test_traffic(30);
    drain_results();
  endtask

  // result ready, with random stalls and a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_trigger) begin
      hold_trigger = 1'b0;
      hold_left    <= HOLD_CYCLES;
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t want;
    result_t got;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = result_if.data;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        words_seen++;
        check_field("event_kind", want.event_kind, got.event_kind);
        check_field("rx_index", want.rx_index, got.rx_index);
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("frame_length", want.frame_length, got.frame_length);
        check_field("gap_count", want.gap_count, got.gap_count);
        check_field("tx_byte", want.tx_byte, got.tx_byte);
        check_field("drive_enable", want.drive_enable, got.drive_enable);
        check_field("rx_phase", want.rx_phase, got.rx_phase);
        check_field("tx_busy", want.tx_busy, got.tx_busy);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    item_if.valid   = 1'b0;
    item_if.data    = '0;
    result_if.ready = 1'b0;
    frame_gap_cfg   = FRAME_GAP_RESET;
    char_gap_cfg    = CHAR_GAP_RESET;
    lk_phase        = PH_INIT;
    lk_tx_on        = 1'b0;
    lk_timer_on     = 1'b0;
    lk_half         = '0;
    lk_gaps         = '0;
    lk_rx_count     = '0;
    lk_rx_en        = 1'b1;
    lk_tx_pending   = '0;
    lk_tx_rd        = '0;
    lk_tx_wr        = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_rx_overflow();
    test_tx_queue_full();

    // random traffic under each idling mode and gap setting
    set_gaps(4'd1, 4'd1);
    test_traffic(20);
    idle_pct = 73;
    set_gaps(4'd15, 4'd15);
    test_traffic(20);
    idle_pct  = 0;
    stall_pct = 73;
    set_gaps(4'd15, 4'd1);
    test_traffic(20);
    idle_pct  = 19;
    stall_pct = 19;
    set_gaps(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
    test_traffic(20);
    set_gaps(4'd2, 4'd15);
    test_traffic(15);

    test_backpressure();
    drain_results();

    $display("covered %0d input words and %0d result words: %0d frames closed, %0d bytes sent",
             items_sent, words_seen, frames_ended, bytes_out);
    $display("including receive overflow, gap saturation, a full transmit store and hold-off");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== rtu_serial_link_framer.f =====
+incdir+hdl
hdl/rtu_slf_pkg.sv
hdl/rtu_slf_stream_if.sv
hdl/rtu_slf_ram.sv
hdl/rtu_serial_link_framer.sv
dv/testbench.sv
